// ===== sv/bsp_pkg.sv =====
// Shared types, command codes and constants for the bit stream packer.
package bsp_pkg;

  localparam int BUFFER_BYTES_DEF = 2048;
  localparam int CMD_W            = 3;
  localparam int VAL_W            = 8;
  localparam int LEN_W            = 15;

  localparam logic [VAL_W-1:0] FAIL_BYTE = 8'hFF;
  localparam logic [VAL_W-1:0] ZERO_BYTE = 8'h00;
  localparam logic [VAL_W-1:0] BIT_MSB   = 8'h80;

  // Command codes on the input channel
  typedef enum logic [CMD_W-1:0] {
    CMD_WR_BIT  = 3'd0,
    CMD_WR_BYTE = 3'd1,
    CMD_RD_BIT  = 3'd2,
    CMD_RD_BYTE = 3'd3,
    CMD_REWIND  = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_t;

  // Buffer operation carried to the merge stage
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_WR_BIT  = 3'd1,
    OP_WR_BYTE = 3'd2,
    OP_RD_BIT  = 3'd3,
    OP_RD_BYTE = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [2:0]       off;          // bit offset of the cursor in its byte
    logic [VAL_W-1:0] wdata;
    logic             first_odd;    // first byte sits in the odd bank
    logic             second_ok;    // second byte lies inside the buffer
    logic [VAL_W-1:0] fixed_value;  // read_value when no buffer data is used
    logic             err;
    logic             ovf;
    logic [LEN_W-1:0] len;
  } op_t;

endpackage

// ===== sv/bsp_bank.sv =====
// One byte-wide buffer bank: one write port, one registered read port.
module bsp_bank #(
  parameter int DEPTH = bsp_pkg::BUFFER_BYTES_DEF / 2
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [bsp_pkg::VAL_W-1:0]       wdata,
  input  logic                            re,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [bsp_pkg::VAL_W-1:0]       rdata
);

  logic [bsp_pkg::VAL_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bsp_issue.sv =====
// Issue stage: cursor, length and error state, bank read addresses, clearing sweep.
module bsp_issue #(
  parameter  int BUFFER_BYTES = bsp_pkg::BUFFER_BYTES_DEF,
  localparam int ED           = (BUFFER_BYTES + 1) / 2,
  localparam int OD           = BUFFER_BYTES / 2,
  localparam int EAW          = $clog2(ED),
  localparam int OAW          = $clog2(OD)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bsp_pkg::CMD_W-1:0]     command,
  input  logic [bsp_pkg::VAL_W-1:0]     write_value,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          hold,
  output logic                          issue_fire,
  output bsp_pkg::op_t                  op,
  output logic                          rd_en,
  output logic [EAW-1:0]                rd_addr_e,
  output logic [OAW-1:0]                rd_addr_o,
  output logic                          sweep_en,
  output logic [EAW-1:0]                sweep_addr
);

  localparam int CAP = BUFFER_BYTES * 8;
  localparam int CW  = $clog2(CAP + 1);
  localparam int IW  = $clog2(BUFFER_BYTES);

  typedef enum logic [1:0] {
    ST_SWEEP = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t         state;
  logic [EAW-1:0] sweep_cnt;
  logic [CW-1:0]  cursor, cursor_next;
  logic [CW-1:0]  written, written_next;
  logic           err_flag, err_next;

  logic [CW:0]    cur_p8, wr_p1, wr_p8;
  logic [CW:0]    cap_x;
  logic [CW-1:0]  len_p1, len_p8;
  logic           room_bit, room_byte, have_byte;
  logic [IW-1:0]  idx;
  logic [IW:0]    idx_p1;
  logic           need_rd, do_clear;

  bsp_pkg::op_kind_t         kind;
  logic [bsp_pkg::VAL_W-1:0] fixed_value;
  logic                      ovf;

  // Bounds and saturating length
  always_comb begin
    cap_x     = (CW+1)'(CAP);
    cur_p8    = {1'b0, cursor} + (CW+1)'(8);
    wr_p1     = {1'b0, written} + (CW+1)'(1);
    wr_p8     = {1'b0, written} + (CW+1)'(8);
    len_p1    = (wr_p1 > cap_x) ? CW'(CAP) : wr_p1[CW-1:0];
    len_p8    = (wr_p8 > cap_x) ? CW'(CAP) : wr_p8[CW-1:0];
    room_bit  = cursor < CW'(CAP);
    room_byte = cur_p8 <= cap_x;
    have_byte = cur_p8 <= {1'b0, written};
    idx       = cursor[IW+2:3];
    idx_p1    = {1'b0, idx} + (IW+1)'(1);
  end

  // Decode the command
  always_comb begin
    cursor_next  = cursor;
    written_next = written;
    err_next     = err_flag;
    kind         = bsp_pkg::OP_NONE;
    fixed_value  = bsp_pkg::ZERO_BYTE;
    ovf          = 1'b0;
    need_rd      = 1'b0;
    do_clear     = 1'b0;
    unique case (command)
      bsp_pkg::CMD_WR_BIT: begin
        if (room_bit) begin
          kind         = bsp_pkg::OP_WR_BIT;
          need_rd      = 1'b1;
          cursor_next  = cursor + CW'(1);
          written_next = len_p1;
        end else begin
          ovf = 1'b1;
        end
      end
      bsp_pkg::CMD_WR_BYTE: begin
        if (room_byte) begin
          kind         = bsp_pkg::OP_WR_BYTE;
          need_rd      = 1'b1;
          cursor_next  = cursor + CW'(8);
          written_next = len_p8;
        end else begin
          ovf = 1'b1;
        end
      end
      bsp_pkg::CMD_RD_BIT: begin
        if (room_bit) begin
          kind        = bsp_pkg::OP_RD_BIT;
          need_rd     = 1'b1;
          cursor_next = cursor + CW'(1);
        end
      end
      bsp_pkg::CMD_RD_BYTE: begin
        if (have_byte) begin
          kind        = bsp_pkg::OP_RD_BYTE;
          need_rd     = 1'b1;
          cursor_next = cursor + CW'(8);
        end else begin
          err_next    = 1'b1;
          fixed_value = bsp_pkg::FAIL_BYTE;
        end
      end
      bsp_pkg::CMD_REWIND: begin
        cursor_next = '0;
      end
      bsp_pkg::CMD_CLEAR: begin
        do_clear     = 1'b1;
        cursor_next  = '0;
        written_next = '0;
        err_next     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Operation record for the merge stage
  always_comb begin
    op.kind        = kind;
    op.off         = cursor[2:0];
    op.wdata       = write_value;
    op.first_odd   = idx[0];
    op.second_ok   = idx_p1 < (IW+1)'(BUFFER_BYTES);
    op.fixed_value = fixed_value;
    op.err         = err_next;
    op.ovf         = ovf;
    op.len         = bsp_pkg::LEN_W'(written_next);
  end

  // Handshake and bank addresses
  assign in_stall   = (state == ST_SWEEP) || hold;
  assign issue_fire = in_valid && !in_stall;
  assign rd_en      = issue_fire && need_rd;
  assign rd_addr_e  = idx_p1[EAW:1];
  assign rd_addr_o  = idx[OAW:1];
  assign sweep_en   = (state == ST_SWEEP);
  assign sweep_addr = sweep_cnt;

  // Control state; a clear starts a new sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      sweep_cnt <= '0;
      cursor    <= '0;
      written   <= '0;
      err_flag  <= 1'b0;
    end else begin
      if (issue_fire) begin
        cursor   <= cursor_next;
        written  <= written_next;
        err_flag <= err_next;
      end
      unique case (state)
        ST_SWEEP: begin
          if (sweep_cnt == EAW'(ED - 1)) begin
            state <= ST_RUN;
          end
          sweep_cnt <= sweep_cnt + EAW'(1);
        end
        ST_RUN: begin
          if (issue_fire && do_clear) begin
            state     <= ST_SWEEP;
            sweep_cnt <= '0;
          end
        end
        default: begin
          state <= ST_SWEEP;
        end
      endcase
    end
  end

endmodule

// ===== sv/bsp_merge.sv =====
// Merge stage: forward, modify and write back bank bytes, drive the result register.
module bsp_merge #(
  parameter  int BUFFER_BYTES = bsp_pkg::BUFFER_BYTES_DEF,
  localparam int ED           = (BUFFER_BYTES + 1) / 2,
  localparam int OD           = BUFFER_BYTES / 2,
  localparam int EAW          = $clog2(ED),
  localparam int OAW          = $clog2(OD)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          issue_fire,
  input  bsp_pkg::op_t                  op_in,
  input  logic                          rd_en,
  input  logic [EAW-1:0]                rd_addr_e,
  input  logic [OAW-1:0]                rd_addr_o,
  input  logic                          sweep_en,
  input  logic [EAW-1:0]                sweep_addr,
  input  logic [bsp_pkg::VAL_W-1:0]     rdata_e,
  input  logic [bsp_pkg::VAL_W-1:0]     rdata_o,
  output logic                          we_e,
  output logic [EAW-1:0]                wa_e,
  output logic [bsp_pkg::VAL_W-1:0]     wd_e,
  output logic                          we_o,
  output logic [OAW-1:0]                wa_o,
  output logic [bsp_pkg::VAL_W-1:0]     wd_o,
  output logic                          hold,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bsp_pkg::VAL_W-1:0]     read_value,
  output logic                          read_error,
  output logic                          overflow,
  output logic [bsp_pkg::LEN_W-1:0]     bit_length
);

  bsp_pkg::op_t              s1_op;
  logic                      s1_valid, s1_fire;
  logic [EAW-1:0]            s1_addr_e;
  logic [OAW-1:0]            s1_addr_o;
  logic                      fwd_e, fwd_o;
  logic [bsp_pkg::VAL_W-1:0] fwd_e_data, fwd_o_data;

  logic [bsp_pkg::VAL_W-1:0] de, dod, b0, b1, n0, n1, rv, mask;
  logic [15:0]               rsh, wsh;
  logic                      w0, w1;

  assign hold    = s1_valid && out_valid && out_stall;
  assign s1_fire = s1_valid && !(out_valid && out_stall);

  // Take the issued operation
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_fire) begin
      s1_op     <= op_in;
      s1_addr_e <= rd_addr_e;
      s1_addr_o <= rd_addr_o;
    end
  end

  // Forward a write that lands in the same cycle as the read of its entry
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_e <= 1'b0;
      fwd_o <= 1'b0;
    end else if (rd_en) begin
      fwd_e      <= we_e && (wa_e == rd_addr_e);
      fwd_o      <= we_o && (wa_o == rd_addr_o);
      fwd_e_data <= wd_e;
      fwd_o_data <= wd_o;
    end
  end

  // Modify the two bytes at the cursor
  always_comb begin
    de   = fwd_e ? fwd_e_data : rdata_e;
    dod  = fwd_o ? fwd_o_data : rdata_o;
    b0   = s1_op.first_odd ? dod : de;
    b1   = s1_op.second_ok ? (s1_op.first_odd ? de : dod) : bsp_pkg::ZERO_BYTE;
    rsh  = {b0, b1} << s1_op.off;
    wsh  = {s1_op.wdata, bsp_pkg::ZERO_BYTE} >> s1_op.off;
    mask = bsp_pkg::BIT_MSB >> s1_op.off;
    n0   = b0;
    n1   = b1;
    w0   = 1'b0;
    w1   = 1'b0;
    rv   = bsp_pkg::ZERO_BYTE;
    unique case (s1_op.kind)
      bsp_pkg::OP_WR_BIT: begin
        n0 = s1_op.wdata[0] ? (b0 | mask) : b0;
        w0 = 1'b1;
      end
      bsp_pkg::OP_WR_BYTE: begin
        n0 = (s1_op.off == 3'd0) ? s1_op.wdata : (b0 | wsh[15:8]);
        n1 = b1 | wsh[7:0];
        w0 = 1'b1;
        w1 = (s1_op.off != 3'd0) && s1_op.second_ok;
      end
      bsp_pkg::OP_RD_BIT: begin
        rv = {7'd0, b0[3'd7 - s1_op.off]};
      end
      bsp_pkg::OP_RD_BYTE: begin
        rv = rsh[15:8];
      end
      default: begin
        rv = s1_op.fixed_value;
      end
    endcase
  end

  // Route writes to the banks; the clearing sweep takes both ports
  always_comb begin
    if (sweep_en) begin
      we_e = 1'b1;
      wa_e = sweep_addr;
      wd_e = bsp_pkg::ZERO_BYTE;
      we_o = {1'b0, sweep_addr} < (EAW+1)'(OD);
      wa_o = OAW'(sweep_addr);
      wd_o = bsp_pkg::ZERO_BYTE;
    end else begin
      we_e = s1_fire && (s1_op.first_odd ? w1 : w0);
      wa_e = s1_addr_e;
      wd_e = s1_op.first_odd ? n1 : n0;
      we_o = s1_fire && (s1_op.first_odd ? w0 : w1);
      wa_o = s1_addr_o;
      wd_o = s1_op.first_odd ? n0 : n1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      read_value <= rv;
      read_error <= s1_op.err;
      overflow   <= s1_op.ovf;
      bit_length <= s1_op.len;
    end
  end

endmodule

// ===== sv/bit_stream_packer.sv =====
// Top level of the MSB-first bit stream packer and unpacker.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall   command, write_value
//   out      from block out_valid / out_stall read_value, read_error, overflow, bit_length
//
// One command is taken per cycle while in_stall is low; its result passes through the
// merge stage register into the output register. The buffer lives in two byte banks
// (even and odd bytes), so each command reads both bytes at the cursor from the banks
// and the merge stage writes them back, with a forwarding path for a back-to-back hit
// on the same entry. After reset and after a clear, a sweep zeroes every entry of the
// banks; in_stall is high during it.
// in_stall also rises while a result waits in a stalled output register and the
// merge stage holds another one.
module bit_stream_packer #(
  parameter  int BUFFER_BYTES = bsp_pkg::BUFFER_BYTES_DEF,
  localparam int ED           = (BUFFER_BYTES + 1) / 2,
  localparam int OD           = BUFFER_BYTES / 2,
  localparam int EAW          = $clog2(ED),
  localparam int OAW          = $clog2(OD)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bsp_pkg::CMD_W-1:0]     command,
  input  logic [bsp_pkg::VAL_W-1:0]     write_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bsp_pkg::VAL_W-1:0]     read_value,
  output logic                          read_error,
  output logic                          overflow,
  output logic [bsp_pkg::LEN_W-1:0]     bit_length
);

  bsp_pkg::op_t              op;
  logic                      hold, issue_fire, rd_en, sweep_en;
  logic [EAW-1:0]            rd_addr_e, sweep_addr, wa_e;
  logic [OAW-1:0]            rd_addr_o, wa_o;
  logic                      we_e, we_o;
  logic [bsp_pkg::VAL_W-1:0] wd_e, wd_o, rdata_e, rdata_o;

  bsp_issue #(.BUFFER_BYTES(BUFFER_BYTES)) u_issue (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .write_value (write_value),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .hold        (hold),
    .issue_fire  (issue_fire),
    .op          (op),
    .rd_en       (rd_en),
    .rd_addr_e   (rd_addr_e),
    .rd_addr_o   (rd_addr_o),
    .sweep_en    (sweep_en),
    .sweep_addr  (sweep_addr)
  );

  bsp_bank #(.DEPTH(ED)) u_bank_e (
    .clk   (clk),
    .we    (we_e),
    .waddr (wa_e),
    .wdata (wd_e),
    .re    (rd_en),
    .raddr (rd_addr_e),
    .rdata (rdata_e)
  );

  bsp_bank #(.DEPTH(OD)) u_bank_o (
    .clk   (clk),
    .we    (we_o),
    .waddr (wa_o),
    .wdata (wd_o),
    .re    (rd_en),
    .raddr (rd_addr_o),
    .rdata (rdata_o)
  );

  bsp_merge #(.BUFFER_BYTES(BUFFER_BYTES)) u_merge (
    .clk        (clk),
    .rst        (rst),
    .issue_fire (issue_fire),
    .op_in      (op),
    .rd_en      (rd_en),
    .rd_addr_e  (rd_addr_e),
    .rd_addr_o  (rd_addr_o),
    .sweep_en   (sweep_en),
    .sweep_addr (sweep_addr),
    .rdata_e    (rdata_e),
    .rdata_o    (rdata_o),
    .we_e       (we_e),
    .wa_e       (wa_e),
    .wd_e       (wd_e),
    .we_o       (we_o),
    .wa_o       (wa_o),
    .wd_o       (wd_o),
    .hold       (hold),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .read_error (read_error),
    .overflow   (overflow),
    .bit_length (bit_length)
  );

endmodule

// ===== verif/bit_stream_packer_test.sv =====
// Self-checking testbench for the MSB-first bit stream packer.
`timescale 1ns / 1ps

module bit_stream_packer_test;

  localparam int BUF_BYTES      = bsp_pkg::BUFFER_BYTES_DEF;
  localparam int CAP_BITS       = BUF_BYTES * 8;
  localparam int IDLE_LIMIT     = 4000;
  localparam int RANDOM_ITEMS   = 940;
  localparam int STREAM_BYTES   = 240;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 8;
  localparam logic [bsp_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [bsp_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [bsp_pkg::VAL_W-1:0] value;
    logic                      err;
    logic                      ovf;
    logic [bsp_pkg::LEN_W-1:0] len;
  } packer_result_t;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic [bsp_pkg::CMD_W-1:0] command     = '0;
  logic [bsp_pkg::VAL_W-1:0] write_value = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic [bsp_pkg::VAL_W-1:0] read_value;
  logic                      read_error;
  logic                      overflow;
  logic [bsp_pkg::LEN_W-1:0] bit_length;

  // Shadow copy of the stream buffer and its pointers
  logic [bsp_pkg::VAL_W-1:0] shadow_bytes [BUF_BYTES];
  int unsigned               shadow_cursor;
  int unsigned               shadow_length;
  logic                      shadow_error;

  packer_result_t   pending_results [$];
  int               issued_count;
  int               checked_count;
  int               mismatch_count;
  int               dropped_writes;
  int               failed_reads;
  int               clear_count;
  int               burst_left;
  int               stall_mode;
  int               stall_left;
  int               stall_phase;

  bit_stream_packer u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .read_error  (read_error),
    .overflow    (overflow),
    .bit_length  (bit_length)
  );

  always #6 clk = ~clk;

  // Zero the shadow buffer and pointers
  function automatic void wipe_shadow();
    foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
    shadow_cursor = 0;
    shadow_length = 0;
    shadow_error  = 1'b0;
  endfunction

  // Add written bits to the length, saturating at capacity
  function automatic void extend_length(int unsigned bits);
    shadow_length = (shadow_length + bits > CAP_BITS) ? CAP_BITS : shadow_length + bits;
  endfunction

  // Apply one command to the shadow state and return the result it produces
  function automatic packer_result_t apply_command(logic [bsp_pkg::CMD_W-1:0] cmd,
                                                   logic [bsp_pkg::VAL_W-1:0] val);
    packer_result_t            res;
    int unsigned               idx;
    int unsigned               off;
    logic [bsp_pkg::VAL_W-1:0] head;
    logic [bsp_pkg::VAL_W-1:0] tail;
    idx = shadow_cursor >> 3;
    off = shadow_cursor & 7;
    res = '0;
    case (cmd)
      bsp_pkg::CMD_WR_BIT: begin
        if (shadow_cursor >= CAP_BITS) begin
          res.ovf = 1'b1;
        end else begin
          if (val[0]) shadow_bytes[idx] = shadow_bytes[idx] | (bsp_pkg::BIT_MSB >> off);
          shadow_cursor++;
          extend_length(1);
        end
      end
      bsp_pkg::CMD_WR_BYTE: begin
        if (shadow_cursor + 8 > CAP_BITS) begin
          res.ovf = 1'b1;
        end else begin
          if (off == 0) begin
            shadow_bytes[idx] = val;
          end else begin
            head = val >> off;
            tail = val << (8 - off);
            shadow_bytes[idx] = shadow_bytes[idx] | head;
            if (idx + 1 < BUF_BYTES) shadow_bytes[idx+1] = shadow_bytes[idx+1] | tail;
          end
          shadow_cursor += 8;
          extend_length(8);
        end
      end
      bsp_pkg::CMD_RD_BIT: begin
        if (shadow_cursor < CAP_BITS) begin
          res.value = {7'd0, shadow_bytes[idx][7-off]};
          shadow_cursor++;
        end
      end
      bsp_pkg::CMD_RD_BYTE: begin
        if (shadow_cursor + 8 > shadow_length) begin
          shadow_error = 1'b1;
          res.value    = bsp_pkg::FAIL_BYTE;
          failed_reads++;
        end else begin
          if (off == 0) begin
            res.value = shadow_bytes[idx];
          end else begin
            head = shadow_bytes[idx] << off;
            tail = (idx + 1 < BUF_BYTES) ? (shadow_bytes[idx+1] >> (8 - off))
                                         : bsp_pkg::ZERO_BYTE;
            res.value = head | tail;
          end
          shadow_cursor += 8;
        end
      end
      bsp_pkg::CMD_REWIND: shadow_cursor = 0;
      bsp_pkg::CMD_CLEAR:  wipe_shadow();
      default: ;
    endcase
    res.err = shadow_error;
    res.len = shadow_length[bsp_pkg::LEN_W-1:0];
    if (res.ovf) dropped_writes++;
    if (cmd == bsp_pkg::CMD_CLEAR) clear_count++;
    return res;
  endfunction

  // Present one command in a burst pattern and hold it until the transfer
  task automatic issue_command(input logic [bsp_pkg::CMD_W-1:0] cmd,
                               input logic [bsp_pkg::VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid    = 1'b1;
    command     = cmd;
    write_value = val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_command(cmd, val));
    issued_count++;
  endtask

  // Short directed walk over every command and the basic corner cases
  task automatic test_directed_commands();
    issue_command(bsp_pkg::CMD_RD_BIT, 8'h00);   // bit read on an empty stream
    issue_command(bsp_pkg::CMD_RD_BYTE, 8'h00);  // byte read past length
    issue_command(CMD_SPARE_6, 8'hFF);
    issue_command(CMD_SPARE_7, 8'h00);
    issue_command(bsp_pkg::CMD_CLEAR, 8'hFF);    // clear drops the sticky error
    issue_command(bsp_pkg::CMD_WR_BIT, 8'hFF);
    issue_command(bsp_pkg::CMD_WR_BIT, 8'hFE);   // only bit 0 counts
    issue_command(bsp_pkg::CMD_WR_BIT, 8'h01);
    issue_command(bsp_pkg::CMD_WR_BYTE, 8'hA5);  // split over two bytes
    issue_command(bsp_pkg::CMD_WR_BYTE, 8'hFF);
    issue_command(bsp_pkg::CMD_WR_BYTE, 8'h00);
    issue_command(bsp_pkg::CMD_REWIND, 8'h00);
    issue_command(bsp_pkg::CMD_RD_BIT, 8'h00);
    issue_command(bsp_pkg::CMD_RD_BIT, 8'h00);
    issue_command(bsp_pkg::CMD_RD_BIT, 8'h00);
    issue_command(bsp_pkg::CMD_RD_BYTE, 8'h00);
    issue_command(bsp_pkg::CMD_RD_BYTE, 8'h00);
    issue_command(bsp_pkg::CMD_RD_BYTE, 8'h00);
    issue_command(bsp_pkg::CMD_RD_BYTE, 8'h00);  // one past the written length
    issue_command(bsp_pkg::CMD_REWIND, 8'h00);
    issue_command(bsp_pkg::CMD_WR_BYTE, 8'h3C);  // aligned write replaces the byte
    issue_command(bsp_pkg::CMD_REWIND, 8'h00);
    issue_command(bsp_pkg::CMD_RD_BYTE, 8'h00);
    issue_command(bsp_pkg::CMD_CLEAR, 8'h00);
  endtask

  // Write a long unaligned stream, then read it all back and one past
  task automatic test_long_stream();
    int k;
    issue_command(bsp_pkg::CMD_CLEAR, 8'h00);
    issue_command(bsp_pkg::CMD_WR_BIT, 8'($urandom));
    for (k = 0; k < STREAM_BYTES; k++) issue_command(bsp_pkg::CMD_WR_BYTE, 8'($urandom));
    issue_command(bsp_pkg::CMD_REWIND, 8'h00);
    issue_command(bsp_pkg::CMD_RD_BIT, 8'h00);
    for (k = 0; k < STREAM_BYTES; k++) issue_command(bsp_pkg::CMD_RD_BYTE, 8'($urandom));
    issue_command(bsp_pkg::CMD_RD_BYTE, 8'h00);
    issue_command(bsp_pkg::CMD_CLEAR, 8'h00);
  endtask

  // Mostly write-rewind-read sessions, with noise, overwrites and clears
  task automatic test_random_sessions();
    int                        goal;
    int                        kind;
    int                        n;
    int                        k;
    logic [bsp_pkg::CMD_W-1:0] cmd;
    goal = issued_count + RANDOM_ITEMS;
    while (issued_count < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        n = $urandom_range(1, 24);
        for (k = 0; k < n; k++)
          issue_command($urandom_range(0, 1) ? bsp_pkg::CMD_WR_BYTE : bsp_pkg::CMD_WR_BIT,
                        8'($urandom));
        issue_command(bsp_pkg::CMD_REWIND, 8'($urandom));
        n = $urandom_range(1, 30);
        for (k = 0; k < n; k++)
          issue_command($urandom_range(0, 1) ? bsp_pkg::CMD_RD_BYTE : bsp_pkg::CMD_RD_BIT,
                        8'($urandom));
      end else if (kind < 85) begin
        n = $urandom_range(1, 16);
        for (k = 0; k < n; k++) begin
          cmd = bsp_pkg::CMD_W'($urandom_range(0, 7));
          if (cmd == bsp_pkg::CMD_CLEAR && $urandom_range(0, 7) != 0) cmd = bsp_pkg::CMD_REWIND;
          issue_command(cmd, 8'($urandom));
        end
      end else if (kind < 92) begin
        issue_command(bsp_pkg::CMD_CLEAR, 8'($urandom));
      end else begin
        issue_command(bsp_pkg::CMD_REWIND, 8'($urandom));
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++)
          issue_command($urandom_range(0, 1) ? bsp_pkg::CMD_WR_BYTE : bsp_pkg::CMD_WR_BIT,
                        8'($urandom));
      end
    end
  endtask

  // Vary the output stall pattern between free, light, heavy and periodic
  always @(negedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      stall_mode  <= 0;
      stall_left  <= 0;
      stall_phase <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(32, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      stall_phase <= (stall_phase + 1) % 8;
      case (stall_mode)
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        3:       out_stall <= (stall_phase < 3);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Compare each result transfer with the oldest pending prediction
  always @(posedge clk) begin
    packer_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result value=%02h err=%0b ovf=%0b len=%0d", $realtime,
                   read_value, read_error, overflow, bit_length);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (read_value !== want.value || read_error !== want.err ||
            overflow !== want.ovf || bit_length !== want.len) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: result %0d expected value=%02h err=%0b ovf=%0b len=%0d,",
                      " got value=%02h err=%0b ovf=%0b len=%0d"},
                     $realtime, checked_count, want.value, want.err, want.ovf, want.len,
                     read_value, read_error, overflow, bit_length);
        end
      end
    end
  end

  // End the run when no transfer happens on either channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no transfer for %0d cycles, %0d results pending", IDLE_LIMIT,
             pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  // Reset, run the tests in turn, drain, and report
  initial begin
    wipe_shadow();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_commands();
    test_long_stream();
    test_random_sessions();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d commands and checked %0d results, including %0d clears,",
             issued_count, checked_count, clear_count);
    $display("%0d dropped writes and %0d failed byte reads; %0d mismatches",
             dropped_writes, failed_reads, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
